/* design/iec_level_meter_ballistics_macros.svh */
// ----------------------------------------------------------------------------
// iec_level_meter_ballistics_macros
// assertion shorthands shared by the level meter modules
// ----------------------------------------------------------------------------
`ifndef IEC_LEVEL_METER_BALLISTICS_MACROS_SVH
`define IEC_LEVEL_METER_BALLISTICS_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define IECM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define IECM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/iecm_pkg.sv */
// ----------------------------------------------------------------------------
// iecm_pkg
// constants, register codes and the iec scale function of the level meter
// ----------------------------------------------------------------------------
package iecm_pkg;

  // digit width of the serial multiplier
  localparam int unsigned MUL_DIGIT = 4;

  // digits per multiplier operation with a fixed-width multiplicand
  localparam int unsigned DIG_MANT = 16 / MUL_DIGIT;  // q1.15 mantissa squared
  localparam int unsigned DIG_DB   = 16 / MUL_DIGIT;  // log2 magnitude to db
  localparam int unsigned DIG_MH   = 12 / MUL_DIGIT;  // scale units times height
  localparam int unsigned DIG_RC   = 20 / MUL_DIGIT;  // divide by 25 via reciprocal

  // db per log2 step, q.16
  localparam logic [18:0] DB_K = 19'd394566;
  // span of the scale in q7.8 db (70 db)
  localparam logic [14:0] DB_SPAN = 15'd17920;
  // ceil(2^23 / 25), exact for quotients of 17-bit values
  localparam logic [18:0] IEC_RECIP = 19'd335545;

  // scale units at the zone boundaries (-10, -6, -3 db)
  localparam logic [16:0] IEC_F_M10 = 17'd76800;
  localparam logic [16:0] IEC_F_M6  = 17'd87040;
  localparam logic [16:0] IEC_F_M3  = 17'd94720;

  // peak colour zones
  localparam logic [1:0] ZONE_TOP = 2'd0;
  localparam logic [1:0] ZONE_M6  = 2'd1;
  localparam logic [1:0] ZONE_M10 = 2'd2;
  localparam logic [1:0] ZONE_LOW = 2'd3;

  // register reset values
  localparam logic [11:0] MH_RST    = 12'd256;
  localparam logic [7:0]  HOLD_RST  = 8'd16;
  localparam logic [31:0] BRATE_RST = 32'd4166118277;
  localparam logic [31:0] PRATE_RST = 32'd4294954411;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_METER_HEIGHT = 2'd0,
    REG_PEAK_HOLD    = 2'd1,
    REG_BAR_DECAY    = 2'd2,
    REG_PEAK_DECAY   = 2'd3
  } iecm_reg_e;

  // piecewise iec scale: db above the floor (q7.8) to units of 1/102400
  function automatic logic [16:0] iecm_iec_units(input logic [14:0] u);
    logic [16:0] w;
    logic [16:0] f;
    w = {2'b00, u};
    if (w < 17'd2560) begin
      f = w;
    end else if (w < 17'd5120) begin
      f = ((w - 17'd2560) << 1) + 17'd2560;
    end else if (w < 17'd7680) begin
      f = (w - 17'd5120) * 17'd3 + 17'd7680;
    end else if (w < 17'd10240) begin
      f = (w - 17'd7680) * 17'd6 + 17'd15360;
    end else if (w < 17'd12800) begin
      f = ((w - 17'd10240) << 3) + 17'd30720;
    end else begin
      f = (w - 17'd12800) * 17'd10 + 17'd51200;
    end
    return f;
  endfunction

endpackage

/* design/iec_level_meter_ballistics.sv */
// ----------------------------------------------------------------------------
// iec_level_meter_ballistics
// iec style peak meter: level to db, iec bar scale, bar decay and peak hold
// ----------------------------------------------------------------------------
// One item at a time. A peak reset beat clears the peak and goes straight to
// the output state. A refresh beat runs a sequence on one shared 4-bit
// digit-serial multiplier: a leading-one search over the level, eight
// mantissa squarings, a db scaling, four scale-to-height conversions (the
// level and the three zone boundaries), and for each of the bar and the
// peak a compare step plus, when it decays, a height product and, unless the
// decayed height is clamped, a squaring of the decay factor. The output state
// then loads the output register. A zero level skips the log, that is the
// leading-one search, the squarings and the db scaling. A finished result
// sits in an output register, so the next beat is accepted while it waits; a
// stalled result holds back the one behind it in the output state, and no
// further beat is accepted meanwhile. Configuration writes are taken while no
// beat is being computed.
// ----------------------------------------------------------------------------
`include "iec_level_meter_ballistics_macros.svh"

module iec_level_meter_ballistics
  import iecm_pkg::*;
#(
  parameter int unsigned LEVEL_BITS  = 24,
  parameter int unsigned HEIGHT_BITS = 12,
  parameter int unsigned FACTOR_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [31:0]            cfg_data_i,
  // input beats
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   func_i,
  input  logic [LEVEL_BITS-1:0]  level_i,
  // result beats
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [HEIGHT_BITS-1:0] bar_height_o,
  output logic [HEIGHT_BITS-1:0] peak_height_o,
  output logic [1:0]             peak_zone_o
);

  localparam int unsigned D       = MUL_DIGIT;
  localparam int unsigned FDIG    = (FACTOR_BITS + D - 1) / D;
  localparam int unsigned LW      = FDIG * D;
  localparam int unsigned PW      = FACTOR_BITS + LW;
  localparam int unsigned CW      = $clog2(FDIG + 1);
  localparam int unsigned HDIG    = (HEIGHT_BITS + D - 1) / D;
  localparam int unsigned BAR_OFS = LW - HDIG * D + FACTOR_BITS;
  localparam int unsigned SHW     = $clog2(LEVEL_BITS);
  localparam int unsigned MAGW    = SHW + 8;
  localparam int unsigned HB      = HEIGHT_BITS;
  localparam int unsigned FB      = FACTOR_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_NORM, S_SQ_GO, S_SQ_WAIT, S_DB_GO, S_DB_WAIT,
    S_FM_GO, S_FM_WAIT, S_RC_GO, S_RC_WAIT, S_BAR, S_BAR_GO, S_BAR_WAIT,
    S_BF_GO, S_BF_WAIT, S_PEAK, S_PK_GO, S_PK_WAIT, S_PF_GO, S_PF_WAIT, S_OUT
  } state_e;

  // which height the scale conversion is producing
  typedef enum logic [1:0] {HS_Y, HS_M10, HS_M6, HS_M3} hsel_e;

  // q0.32 register value to a q0.FACTOR_BITS factor
  function automatic logic [FB-1:0] load_fac(input logic [31:0] r);
    logic [FB+31:0] ext;
    ext = {r, {FB{1'b0}}};
    return ext[32 +: FB];
  endfunction

  state_e           st_q;
  hsel_e            hs_q;
  logic [11:0]      mh_q;
  logic [7:0]       hold_q;
  logic [31:0]      brate_q;
  logic [31:0]      prate_q;
  logic [LEVEL_BITS-1:0] norm_q;
  logic [SHW-1:0]   sh_q;
  logic [15:0]      m_q;
  logic [7:0]       frac_q;
  logic [2:0]       it_q;
  logic [14:0]      u_q;
  logic [HB-1:0]    y_q;
  logic [HB-1:0]    lev10_q;
  logic [HB-1:0]    lev6_q;
  logic [HB-1:0]    lev3_q;
  logic [HB-1:0]    bar_q;
  logic [HB-1:0]    pk_q;
  logic [FB-1:0]    bf_q;
  logic [FB-1:0]    pf_q;
  logic [7:0]       wait_q;
  logic [1:0]       pz_q;
  logic [HB-1:0]    ob_q;
  logic [HB-1:0]    op_q;
  logic [1:0]       oz_q;
  logic             ovld_q;

  logic             mul_start;
  logic [FB-1:0]    mul_a;
  logic [LW-1:0]    mul_b;
  logic [CW-1:0]    mul_nd;
  logic             mul_done;
  logic [PW-1:0]    prod;

  logic [16:0]      m2;
  logic             sq_bit;
  logic [15:0]      m_next;
  logic [MAGW-1:0]  mag;
  logic [15:0]      q_db;
  logic [14:0]      u_db;
  logic [16:0]      f_sel;
  logic [16:0]      xs;
  logic [HB-1:0]    h_rc;
  logic [HB-1:0]    h_mul;
  logic [FB-1:0]    f_sq;
  logic [1:0]       zone;
  logic [7:0]       wait_inc;

  // product fields for each multiplier operation
  always_comb begin
    m2     = prod[LW-1 +: 17];
    sq_bit = m2[16];
    m_next = sq_bit ? m2[16:1] : m2[15:0];
    mag    = {sh_q, 8'h00} - MAGW'(frac_q);
    q_db   = prod[LW +: 16];
    xs     = prod[LW +: 17];
    h_rc   = prod[LW+3 +: HB];
    h_mul  = prod[BAR_OFS +: HB];
    f_sq   = prod[FB +: FB];
    if (sh_q == '0) begin
      u_db = DB_SPAN;
    end else if (q_db >= {1'b0, DB_SPAN}) begin
      u_db = '0;
    end else begin
      u_db = 15'({1'b0, DB_SPAN} - q_db);
    end
  end

  // scale units for the height being converted
  always_comb begin
    unique case (hs_q)
      HS_Y:    f_sel = iecm_iec_units(u_q);
      HS_M10:  f_sel = IEC_F_M10;
      HS_M6:   f_sel = IEC_F_M6;
      HS_M3:   f_sel = IEC_F_M3;
      default: f_sel = iecm_iec_units(u_q);
    endcase
  end

  // zone of the current bar and the saturating hold counter
  always_comb begin
    if (bar_q < lev10_q) begin
      zone = ZONE_LOW;
    end else if (bar_q < lev6_q) begin
      zone = ZONE_M10;
    end else if (bar_q < lev3_q) begin
      zone = ZONE_M6;
    end else begin
      zone = ZONE_TOP;
    end
    wait_inc = (wait_q == 8'hFF) ? wait_q : wait_q + 8'd1;
  end

  // multiplier requests, issued from the launch states
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    mul_nd    = '0;
    unique case (st_q)
      S_SQ_GO: begin
        mul_start = 1'b1;
        mul_a     = FB'(m_q);
        mul_b     = LW'(m_q);
        mul_nd    = CW'(DIG_MANT);
      end
      S_DB_GO: begin
        mul_start = 1'b1;
        mul_a     = FB'(DB_K);
        mul_b     = LW'(mag);
        mul_nd    = CW'(DIG_DB);
      end
      S_FM_GO: begin
        mul_start = 1'b1;
        mul_a     = FB'(f_sel);
        mul_b     = LW'(mh_q);
        mul_nd    = CW'(DIG_MH);
      end
      S_RC_GO: begin
        mul_start = 1'b1;
        mul_a     = FB'(IEC_RECIP);
        mul_b     = LW'(xs);
        mul_nd    = CW'(DIG_RC);
      end
      S_BAR_GO: begin
        mul_start = 1'b1;
        mul_a     = bf_q;
        mul_b     = LW'(bar_q);
        mul_nd    = CW'(HDIG);
      end
      S_BF_GO: begin
        mul_start = 1'b1;
        mul_a     = bf_q;
        mul_b     = LW'(bf_q);
        mul_nd    = CW'(FDIG);
      end
      S_PK_GO: begin
        mul_start = 1'b1;
        mul_a     = pf_q;
        mul_b     = LW'(pk_q);
        mul_nd    = CW'(HDIG);
      end
      S_PF_GO: begin
        mul_start = 1'b1;
        mul_a     = pf_q;
        mul_b     = LW'(pf_q);
        mul_nd    = CW'(FDIG);
      end
      default: ;
    endcase
  end

  iecm_smul #(
    .FACTOR_BITS(FACTOR_BITS)
  ) u_smul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .ndig_i (mul_nd),
    .done_o (mul_done),
    .prod_o (prod)
  );

  // sequencer, meter state, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      hs_q    <= HS_Y;
      mh_q    <= MH_RST;
      hold_q  <= HOLD_RST;
      brate_q <= BRATE_RST;
      prate_q <= PRATE_RST;
      norm_q  <= '0;
      sh_q    <= '0;
      m_q     <= '0;
      frac_q  <= '0;
      it_q    <= '0;
      u_q     <= '0;
      y_q     <= '0;
      lev10_q <= '0;
      lev6_q  <= '0;
      lev3_q  <= '0;
      bar_q   <= '0;
      pk_q    <= '0;
      bf_q    <= load_fac(BRATE_RST);
      pf_q    <= load_fac(PRATE_RST);
      wait_q  <= '0;
      pz_q    <= ZONE_LOW;
      ob_q    <= '0;
      op_q    <= '0;
      oz_q    <= ZONE_LOW;
      ovld_q  <= 1'b0;
    end else begin
      // result beat taken with no new result to load behind it
      if (ovld_q && out_ready_i && st_q != S_OUT) begin
        ovld_q <= 1'b0;
      end

      unique case (st_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (func_i) begin
              pk_q <= '0;
              st_q <= S_OUT;
            end else if (level_i == '0) begin
              u_q  <= '0;
              hs_q <= HS_Y;
              st_q <= S_FM_GO;
            end else begin
              norm_q <= level_i;
              sh_q   <= '0;
              st_q   <= S_NORM;
            end
          end
        end
        // leading-one search, one bit per cycle
        S_NORM: begin
          if (norm_q[LEVEL_BITS-1]) begin
            m_q    <= norm_q[LEVEL_BITS-1 -: 16];
            frac_q <= '0;
            it_q   <= '0;
            st_q   <= S_SQ_GO;
          end else begin
            norm_q <= norm_q << 1;
            sh_q   <= sh_q + SHW'(1);
          end
        end
        S_SQ_GO: st_q <= S_SQ_WAIT;
        // one fraction bit of log2 per squaring
        S_SQ_WAIT: begin
          if (mul_done) begin
            m_q    <= m_next;
            frac_q <= {frac_q[6:0], sq_bit};
            it_q   <= it_q + 3'd1;
            st_q   <= (it_q == 3'd7) ? S_DB_GO : S_SQ_GO;
          end
        end
        S_DB_GO: st_q <= S_DB_WAIT;
        S_DB_WAIT: begin
          if (mul_done) begin
            u_q  <= u_db;
            hs_q <= HS_Y;
            st_q <= S_FM_GO;
          end
        end
        S_FM_GO: st_q <= S_FM_WAIT;
        S_FM_WAIT: begin
          if (mul_done) begin
            st_q <= S_RC_GO;
          end
        end
        S_RC_GO: st_q <= S_RC_WAIT;
        // height ready: store it and move on to the next boundary
        S_RC_WAIT: begin
          if (mul_done) begin
            unique case (hs_q)
              HS_Y: begin
                y_q  <= h_rc;
                hs_q <= HS_M10;
                st_q <= S_FM_GO;
              end
              HS_M10: begin
                lev10_q <= h_rc;
                hs_q    <= HS_M6;
                st_q    <= S_FM_GO;
              end
              HS_M6: begin
                lev6_q <= h_rc;
                hs_q   <= HS_M3;
                st_q   <= S_FM_GO;
              end
              HS_M3: begin
                lev3_q <= h_rc;
                st_q   <= S_BAR;
              end
              default: st_q <= S_BAR;
            endcase
          end
        end
        // bar follows a rise at once, else decays
        S_BAR: begin
          if (bar_q < y_q) begin
            bar_q <= y_q;
            bf_q  <= load_fac(brate_q);
            st_q  <= S_PEAK;
          end else begin
            st_q <= S_BAR_GO;
          end
        end
        S_BAR_GO: st_q <= S_BAR_WAIT;
        S_BAR_WAIT: begin
          if (mul_done) begin
            if (h_mul < y_q) begin
              bar_q <= y_q;
              st_q  <= S_PEAK;
            end else begin
              bar_q <= h_mul;
              st_q  <= S_BF_GO;
            end
          end
        end
        S_BF_GO: st_q <= S_BF_WAIT;
        S_BF_WAIT: begin
          if (mul_done) begin
            bf_q <= f_sq;
            st_q <= S_PEAK;
          end
        end
        // peak: new peak, hold, or decay after the hold time
        S_PEAK: begin
          if (pk_q < bar_q) begin
            pk_q   <= bar_q;
            wait_q <= '0;
            pf_q   <= load_fac(prate_q);
            pz_q   <= zone;
            st_q   <= S_OUT;
          end else begin
            wait_q <= wait_inc;
            st_q   <= (wait_inc > hold_q) ? S_PK_GO : S_OUT;
          end
        end
        S_PK_GO: st_q <= S_PK_WAIT;
        S_PK_WAIT: begin
          if (mul_done) begin
            if (h_mul < bar_q) begin
              pk_q <= bar_q;
              st_q <= S_OUT;
            end else begin
              pk_q <= h_mul;
              if (h_mul < lev10_q) begin
                pz_q <= ZONE_LOW;
              end
              st_q <= S_PF_GO;
            end
          end
        end
        S_PF_GO: st_q <= S_PF_WAIT;
        S_PF_WAIT: begin
          if (mul_done) begin
            pf_q <= f_sq;
            st_q <= S_OUT;
          end
        end
        // hand the result to the output register once it is free
        S_OUT: begin
          if (!ovld_q || out_ready_i) begin
            ob_q   <= bar_q;
            op_q   <= pk_q;
            oz_q   <= pz_q;
            ovld_q <= 1'b1;
            st_q   <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase

      // configuration write, only taken in idle
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (iecm_reg_e'(cfg_index_i))
          REG_METER_HEIGHT: begin
            mh_q <= cfg_data_i[11:0];
            // a peak reset beat in the same cycle clears it already
            if (!(in_valid_i && func_i)) begin
              pk_q <= '0;
            end
          end
          REG_PEAK_HOLD:  hold_q  <= cfg_data_i[7:0];
          REG_BAR_DECAY:  brate_q <= cfg_data_i;
          REG_PEAK_DECAY: prate_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign cfg_ready_o   = (st_q == S_IDLE);
  assign in_ready_o    = (st_q == S_IDLE);
  assign out_valid_o   = ovld_q;
  assign bar_height_o  = ob_q;
  assign peak_height_o = op_q;
  assign peak_zone_o   = oz_q;

  `IECM_ASSERT_SAME(a_done_in_wait, mul_done,
                    (st_q == S_SQ_WAIT || st_q == S_DB_WAIT || st_q == S_FM_WAIT ||
                     st_q == S_RC_WAIT || st_q == S_BAR_WAIT || st_q == S_BF_WAIT ||
                     st_q == S_PK_WAIT || st_q == S_PF_WAIT), "multiplier done out of turn")
  `IECM_ASSERT_SAME(a_zone_order, (st_q == S_PEAK),
                    (lev10_q <= lev6_q && lev6_q <= lev3_q), "zone boundaries out of order")
  `IECM_ASSERT_NEXT(a_peak_reset, (in_valid_i && in_ready_o && func_i),
                    (st_q == S_OUT && pk_q == '0), "peak reset not applied")

endmodule

/* design/iecm_smul.sv */
// ----------------------------------------------------------------------------
// iecm_smul
// digit-serial shift-and-add multiplier, multiplier operand lsb digit first
// ----------------------------------------------------------------------------
`include "iec_level_meter_ballistics_macros.svh"

module iecm_smul
  import iecm_pkg::*;
#(
  parameter int unsigned FACTOR_BITS = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [FACTOR_BITS-1:0]                 a_i,
  input  logic [((FACTOR_BITS+MUL_DIGIT-1)/MUL_DIGIT)*MUL_DIGIT-1:0] b_i,
  input  logic [$clog2((FACTOR_BITS+MUL_DIGIT-1)/MUL_DIGIT+1)-1:0]   ndig_i,
  output logic                                   done_o,
  output logic [FACTOR_BITS+((FACTOR_BITS+MUL_DIGIT-1)/MUL_DIGIT)*MUL_DIGIT-1:0] prod_o
);

  localparam int unsigned D    = MUL_DIGIT;
  localparam int unsigned NDIG = (FACTOR_BITS + D - 1) / D;
  localparam int unsigned LW   = NDIG * D;
  localparam int unsigned CW   = $clog2(NDIG + 1);

  logic [FACTOR_BITS-1:0]   a_q;
  logic [FACTOR_BITS-1:0]   hi_q;
  logic [LW-1:0]            lo_q;
  logic [CW-1:0]            cnt_q;
  logic                     busy_q;
  logic                     done_q;
  logic [FACTOR_BITS+D-1:0] pp;
  logic [FACTOR_BITS+D-1:0] acc;

  // one digit partial product added into the upper half
  always_comb begin
    pp  = {{D{1'b0}}, a_q} * {{FACTOR_BITS{1'b0}}, lo_q[D-1:0]};
    acc = {{D{1'b0}}, hi_q} + pp;
  end

  // control: digit counter and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= ndig_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: product bits shift in at the top of the multiplier register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= acc[D +: FACTOR_BITS];
      lo_q <= {acc[D-1:0], lo_q[LW-1:D]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

  `IECM_ASSERT_SAME(a_start_idle, start_i, (!busy_q && ndig_i != '0), "start while busy")
  `IECM_ASSERT_NEXT(a_start_cnt, start_i, (busy_q && cnt_q == $past(ndig_i)), "bad digit count")
  `IECM_ASSERT_NEXT(a_last_digit, (busy_q && cnt_q == CW'(1) && !start_i),
                    (done_q && !busy_q), "missing done")

endmodule
